// ----- rtl/core/cbb_pkg.sv -----
// Shared types, constants and the arctangent table for the compound body
// bounding box block. No dependencies.
`timescale 1ns / 1ps

package cbb_pkg;

    typedef struct packed {
        logic              kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] prim_angle;
        logic signed [15:0] body_angle;
        logic [30:0]       width;
        logic [30:0]       height;
        logic [30:0]       radius;
        logic              last;
        logic              is_empty;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic [30:0]       span_x;
        logic [30:0]       span_y;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_EMPTY,
        CLS_CIRCLE,
        CLS_RECT
    } t_cls;

    typedef struct packed {
        t_cls     cls;
        t_in_item item;
    } t_qitem;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_CORD,
        ST_MUL,
        ST_ROUND,
        ST_EDGE,
        ST_MERGE,
        ST_OUT
    } t_state;

    localparam int Z_W          = 35;
    localparam int XY_W         = 34;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int MUL_TERMS    = 4;

    localparam logic signed [Z_W-1:0]  PI_Q28      = 35'sd843314857;
    localparam logic signed [Z_W-1:0]  TWO_PI_Q28  = 35'sd1686629713;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q28 = 35'sd421657428;
    localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

    function automatic logic signed [Z_W-1:0] atan_q28(input logic [STEP_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            4'd0:    v = 35'sd210828714;
            4'd1:    v = 35'sd124459457;
            4'd2:    v = 35'sd65760959;
            4'd3:    v = 35'sd33381290;
            4'd4:    v = 35'sd16755422;
            4'd5:    v = 35'sd8385879;
            4'd6:    v = 35'sd4193963;
            4'd7:    v = 35'sd2097109;
            4'd8:    v = 35'sd1048571;
            4'd9:    v = 35'sd524287;
            4'd10:   v = 35'sd262144;
            4'd11:   v = 35'sd131072;
            4'd12:   v = 35'sd65536;
            4'd13:   v = 35'sd32768;
            4'd14:   v = 35'sd16384;
            default: v = 35'sd8192;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/cbb_front.sv -----
// Front end: takes input transactions, tags each with its class and holds
// them in a two-entry queue for the back end. Depends on cbb_pkg.
`timescale 1ns / 1ps

module cbb_front
    import cbb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_ready,
    output t_qitem   o_q_item
);

    t_qitem     r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    t_qitem     w_entry;
    logic       w_push, w_pop;

    always_comb begin
        w_entry.item = i_item;
        if (i_item.is_empty) begin
            w_entry.cls = CLS_EMPTY;
        end else if (i_item.kind) begin
            w_entry.cls = CLS_CIRCLE;
        end else begin
            w_entry.cls = CLS_RECT;
        end
    end

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ----- rtl/core/cbb_back.sv -----
// Back end: angle reduction, shared iterative CORDIC, one shared multiplier,
// box merge and the output register. Depends on cbb_pkg.
`timescale 1ns / 1ps

module cbb_back
    import cbb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    output logic      o_q_ready,
    input  t_qitem    i_q_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -37'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [30:0] span(input logic signed [31:0] mx,
                                         input logic signed [31:0] mn);
        logic signed [32:0] d;
        logic [30:0]        r;
        d = {mx[31], mx} - {mn[31], mn};
        if (d[32]) begin
            r = '0;
        end else if (d[31]) begin
            r = '1;
        end else begin
            r = d[30:0];
        end
        return r;
    endfunction

    t_state r_state, n_state;
    t_cls   r_cls, n_cls;
    t_in_item r_item, n_item;
    logic   r_pass, n_pass;
    logic   r_neg, n_neg;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic signed [XY_W-1:0] r_x, n_x, r_y, n_y;
    logic signed [31:0] r_bc, n_bc, r_bs, n_bs, r_pc, n_pc, r_ps, n_ps;
    logic signed [63:0] r_prod, n_prod;
    logic signed [65:0] r_acc_x, n_acc_x, r_acc_y, n_acc_y;
    logic signed [35:0] r_rx, n_rx, r_ry, n_ry, r_hx, n_hx, r_hy, n_hy;
    logic signed [31:0] r_mnx, n_mnx, r_mxx, n_mxx, r_mny, n_mny, r_mxy, n_mxy;
    logic signed [31:0] r_run_mnx, n_run_mnx, r_run_mxx, n_run_mxx;
    logic signed [31:0] r_run_mny, n_run_mny, r_run_mxy, n_run_mxy;
    logic   r_have_first, n_have_first;
    logic   r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic   w_out_free;
    logic signed [XY_W-1:0] w_cx, w_cy;
    logic signed [Z_W-1:0]  w_cz;
    logic signed [XY_W-1:0] w_cres_x, w_cres_y;
    logic signed [31:0] w_op_a, w_op_b;
    logic signed [63:0] w_prod_abs;
    logic signed [65:0] w_prod_ext, w_rnd_x, w_rnd_y;
    logic [STEP_W-1:0]  w_acc_idx;
    logic signed [16:0] w_angle_sum;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_q_ready  = (r_state == ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    // one CORDIC rotation step
    always_comb begin
        if (!r_z[Z_W-1]) begin
            w_cx = r_x - (r_y >>> r_cnt);
            w_cy = r_y + (r_x >>> r_cnt);
            w_cz = r_z - atan_q28(r_cnt);
        end else begin
            w_cx = r_x + (r_y >>> r_cnt);
            w_cy = r_y - (r_x >>> r_cnt);
            w_cz = r_z + atan_q28(r_cnt);
        end
        w_cres_x = r_neg ? -w_cx : w_cx;
        w_cres_y = r_neg ? -w_cy : w_cy;
    end

    // multiplier operand selection
    always_comb begin
        w_op_a = r_item.pos_x;
        w_op_b = r_bc;
        case ({r_pass, r_cnt[1:0]})
            3'b000: begin w_op_a = r_item.pos_x; w_op_b = r_bc; end
            3'b001: begin w_op_a = r_item.pos_y; w_op_b = r_bs; end
            3'b010: begin w_op_a = r_item.pos_x; w_op_b = r_bs; end
            3'b011: begin w_op_a = r_item.pos_y; w_op_b = r_bc; end
            3'b100: begin w_op_a = $signed({1'b0, r_item.width});  w_op_b = r_pc; end
            3'b101: begin w_op_a = $signed({1'b0, r_item.height}); w_op_b = r_ps; end
            3'b110: begin w_op_a = $signed({1'b0, r_item.width});  w_op_b = r_ps; end
            default: begin w_op_a = $signed({1'b0, r_item.height}); w_op_b = r_pc; end
        endcase
        w_prod_abs = r_prod[63] ? -r_prod : r_prod;
        w_prod_ext = r_pass ? {2'b00, w_prod_abs} : {{2{r_prod[63]}}, r_prod};
        w_acc_idx  = r_cnt - STEP_W'(1);
        w_rnd_x    = r_acc_x + (r_pass ? 66'sd1073741824 : 66'sd536870912);
        w_rnd_y    = r_acc_y + (r_pass ? 66'sd1073741824 : 66'sd536870912);
        w_angle_sum = {r_item.prim_angle[15], r_item.prim_angle}
                    + {r_item.body_angle[15], r_item.body_angle};
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) n_state = (i_q_item.cls == CLS_EMPTY) ? ST_OUT : ST_RED;
            end
            ST_RED: begin
                if (!(r_z > PI_Q28) && !(r_z < -PI_Q28)) n_state = ST_CORD;
            end
            ST_CORD: begin
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == STEP_W'(MUL_TERMS)) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                if (!r_pass && r_cls == CLS_RECT) n_state = ST_RED;
                else n_state = ST_EDGE;
            end
            ST_EDGE:  n_state = ST_MERGE;
            ST_MERGE: n_state = r_item.last ? ST_OUT : ST_IDLE;
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_cls = r_cls;   n_item = r_item; n_pass = r_pass; n_neg = r_neg;
        n_cnt = r_cnt;   n_z = r_z;       n_x = r_x;       n_y = r_y;
        n_bc = r_bc;     n_bs = r_bs;     n_pc = r_pc;     n_ps = r_ps;
        n_prod = r_prod; n_acc_x = r_acc_x; n_acc_y = r_acc_y;
        n_rx = r_rx; n_ry = r_ry; n_hx = r_hx; n_hy = r_hy;
        n_mnx = r_mnx; n_mxx = r_mxx; n_mny = r_mny; n_mxy = r_mxy;
        n_run_mnx = r_run_mnx; n_run_mxx = r_run_mxx;
        n_run_mny = r_run_mny; n_run_mxy = r_run_mxy;
        n_have_first = r_have_first;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cls  = i_q_item.cls;
                    n_item = i_q_item.item;
                    n_pass = 1'b0;
                    n_z    = {{3{i_q_item.item.body_angle[15]}},
                              i_q_item.item.body_angle, 16'd0};
                end
            end
            ST_RED: begin
                if (r_z > PI_Q28) begin
                    n_z = r_z - TWO_PI_Q28;
                end else if (r_z < -PI_Q28) begin
                    n_z = r_z + TWO_PI_Q28;
                end else begin
                    n_neg = 1'b1;
                    if (r_z > HALF_PI_Q28) begin
                        n_z = r_z - PI_Q28;
                    end else if (r_z < -HALF_PI_Q28) begin
                        n_z = r_z + PI_Q28;
                    end else begin
                        n_neg = 1'b0;
                    end
                    n_x   = GAIN_Q30;
                    n_y   = '0;
                    n_cnt = '0;
                end
            end
            ST_CORD: begin
                n_x   = w_cx;
                n_y   = w_cy;
                n_z   = w_cz;
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_cnt = '0;
                    if (r_pass) begin
                        n_pc = w_cres_x[31:0];
                        n_ps = w_cres_y[31:0];
                    end else begin
                        n_bc = w_cres_x[31:0];
                        n_bs = w_cres_y[31:0];
                    end
                end
            end
            ST_MUL: begin
                n_prod = w_op_a * w_op_b;
                n_cnt  = r_cnt + STEP_W'(1);
                if (r_cnt != '0) begin
                    case ({r_pass, w_acc_idx[1:0]})
                        3'b000, 3'b100: n_acc_x = w_prod_ext;
                        3'b001:         n_acc_x = r_acc_x - w_prod_ext;
                        3'b101:         n_acc_x = r_acc_x + w_prod_ext;
                        3'b010, 3'b110: n_acc_y = w_prod_ext;
                        default:        n_acc_y = r_acc_y + w_prod_ext;
                    endcase
                end
            end
            ST_ROUND: begin
                n_cnt = '0;
                if (r_pass) begin
                    n_hx = {w_rnd_x[65], w_rnd_x[65:31]};
                    n_hy = {w_rnd_y[65], w_rnd_y[65:31]};
                end else begin
                    n_rx = w_rnd_x[65:30];
                    n_ry = w_rnd_y[65:30];
                    n_hx = {5'd0, r_item.radius};
                    n_hy = {5'd0, r_item.radius};
                    n_pass = 1'b1;
                    n_z = {{2{w_angle_sum[16]}}, w_angle_sum, 16'd0};
                end
            end
            ST_EDGE: begin
                n_mnx = sat32({r_rx[35], r_rx} - {r_hx[35], r_hx});
                n_mxx = sat32({r_rx[35], r_rx} + {r_hx[35], r_hx});
                n_mny = sat32({r_ry[35], r_ry} - {r_hy[35], r_hy});
                n_mxy = sat32({r_ry[35], r_ry} + {r_hy[35], r_hy});
            end
            ST_MERGE: begin
                n_have_first = 1'b1;
                if (!r_have_first || r_mnx < r_run_mnx) n_run_mnx = r_mnx;
                if (!r_have_first || r_mxx > r_run_mxx) n_run_mxx = r_mxx;
                if (!r_have_first || r_mny < r_run_mny) n_run_mny = r_mny;
                if (!r_have_first || r_mxy > r_run_mxy) n_run_mxy = r_mxy;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_have_first = 1'b0;
                    if (r_cls == CLS_EMPTY) begin
                        n_out = '0;
                    end else begin
                        n_out.min_x  = r_run_mnx;
                        n_out.max_x  = r_run_mxx;
                        n_out.min_y  = r_run_mny;
                        n_out.max_y  = r_run_mxy;
                        n_out.span_x = span(r_run_mxx, r_run_mnx);
                        n_out.span_y = span(r_run_mxy, r_run_mny);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cls <= n_cls;   r_item <= n_item; r_pass <= n_pass; r_neg <= n_neg;
        r_cnt <= n_cnt;   r_z <= n_z;       r_x <= n_x;       r_y <= n_y;
        r_bc <= n_bc;     r_bs <= n_bs;     r_pc <= n_pc;     r_ps <= n_ps;
        r_prod <= n_prod; r_acc_x <= n_acc_x; r_acc_y <= n_acc_y;
        r_rx <= n_rx; r_ry <= n_ry; r_hx <= n_hx; r_hy <= n_hy;
        r_mnx <= n_mnx; r_mxx <= n_mxx; r_mny <= n_mny; r_mxy <= n_mxy;
        r_run_mnx <= n_run_mnx; r_run_mxx <= n_run_mxx;
        r_run_mny <= n_run_mny; r_run_mxy <= n_run_mxy;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_have_first <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_have_first <= n_have_first;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

// ----- rtl/core/compound_body_bounding_box.sv -----
// Top level of the compound body bounding box block: front queue, back-end
// sequencer and assertions. Depends on cbb_pkg, cbb_front and cbb_back.
`timescale 1ns / 1ps

// Each input transaction carries one primitive (rectangle or circle) of a
// body, with the body angle; the transaction marked last returns the body's
// axis-aligned box (min, max, spans) and one marked empty returns an all-zero
// box. A two-entry queue takes transactions while the back end works, and a
// finished box waits in an output register without blocking the queue.
// The back end handles one primitive at a time, with the shared 16-step
// CORDIC and the single 32x32 multiplier (four products per pass): each
// angle is first reduced by whole turns, a rectangle needs a second CORDIC
// and multiply pass, the last primitive then loads the output register, and
// an empty body goes straight to it.
module compound_body_bounding_box
    import cbb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic   q_valid, q_ready;
    t_qitem q_item;

    // front: classify and queue
    cbb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    // back: rotate, size, merge, emit
    cbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_item  (q_item),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

    // a full queue must be offering a transaction to the back end
    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> q_valid)
        else $error("queue full but empty to back end");

    // the back end takes one transaction and is busy the next cycle
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready) |=> !q_ready)
        else $error("back end took a transaction and stayed idle");

endmodule

// ----- tb/compound_body_bounding_box_tb.sv -----
// Self-checking testbench for compound_body_bounding_box: random bodies of
// rectangles and circles, checked against an in-bench box predictor.
// Depends on cbb_pkg (transaction types) and the block itself.
`timescale 1ns / 1ps

// Box predictor and store of expected boxes. Every accepted non-empty input
// transaction is folded into the running box; a transaction that closes a
// body (last or empty) queues the box the block must return.
class box_scoreboard;
    localparam longint TURN_Q28  = 1686629713;
    localparam longint HALF_TURN = 843314857;
    localparam longint QUARTER   = 421657428;
    localparam longint K_GAIN    = 652032874;
    localparam longint MAX_POS   = 2147483647;
    localparam longint MAX_NEG   = -64'sd2147483648;

    longint arctan [16] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                            8385879, 4193963, 2097109, 1048571, 524287, 262144,
                            131072, 65536, 32768, 16384, 8192};
    longint box_lo_x, box_hi_x, box_lo_y, box_hi_y;
    bit     box_open;
    cbb_pkg::t_out_item boxes_due[$];
    int     mismatches;

    function void clear();
        box_open = 0;
        boxes_due.delete();
        mismatches = 0;
    endfunction

    // Rotation-mode CORDIC, 16 steps, after folding into [-pi/2, pi/2].
    function void sin_cos(longint ang, output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z = ang * 65536;
        x = K_GAIN;
        y = 0;
        flip = 0;
        while (z > HALF_TURN) z -= TURN_Q28;
        while (z < -HALF_TURN) z += TURN_Q28;
        if (z > QUARTER) begin
            z -= HALF_TURN;
            flip = 1;
        end else if (z < -QUARTER) begin
            z += HALF_TURN;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan[i];
            end else begin
                x += dx; y -= dy; z += arctan[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function longint clip32(longint v);
        if (v > MAX_POS) return MAX_POS;
        if (v < MAX_NEG) return MAX_NEG;
        return v;
    endfunction

    function longint clip_span(longint v);
        if (v < 0) return 0;
        if (v > MAX_POS) return MAX_POS;
        return v;
    endfunction

    function void note_input(cbb_pkg::t_in_item it);
        longint ox, oy, wd, ht, bc, bs, c, s, rx, ry, hx, hy, lx, ux, ly, uy;
        cbb_pkg::t_out_item bx;
        if (it.is_empty) begin
            box_open = 0;
            boxes_due.push_back('0);
            return;
        end
        ox = longint'($signed(it.pos_x));
        oy = longint'($signed(it.pos_y));
        sin_cos(longint'($signed(it.body_angle)), bc, bs);
        rx = (ox * bc - oy * bs + (64'sd1 << 29)) >>> 30;
        ry = (ox * bs + oy * bc + (64'sd1 << 29)) >>> 30;
        if (it.kind) begin
            hx = longint'({1'b0, it.radius});
            hy = hx;
        end else begin
            wd = longint'({1'b0, it.width});
            ht = longint'({1'b0, it.height});
            sin_cos(longint'($signed(it.prim_angle)) + longint'($signed(it.body_angle)),
                    c, s);
            hx = mag(wd * c - ht * s);
            if (mag(wd * c + ht * s) > hx) hx = mag(wd * c + ht * s);
            hy = mag(wd * s + ht * c);
            if (mag(wd * s - ht * c) > hy) hy = mag(wd * s - ht * c);
            hx = (hx + (64'sd1 << 30)) >>> 31;
            hy = (hy + (64'sd1 << 30)) >>> 31;
        end
        lx = clip32(rx - hx); ux = clip32(rx + hx);
        ly = clip32(ry - hy); uy = clip32(ry + hy);
        if (box_open) begin
            if (lx < box_lo_x) box_lo_x = lx;
            if (ux > box_hi_x) box_hi_x = ux;
            if (ly < box_lo_y) box_lo_y = ly;
            if (uy > box_hi_y) box_hi_y = uy;
        end else begin
            box_lo_x = lx; box_hi_x = ux; box_lo_y = ly; box_hi_y = uy;
        end
        box_open = 1;
        if (!it.last) return;
        bx.min_x  = box_lo_x[31:0];
        bx.max_x  = box_hi_x[31:0];
        bx.min_y  = box_lo_y[31:0];
        bx.max_y  = box_hi_y[31:0];
        bx.span_x = 31'(clip_span(box_hi_x - box_lo_x));
        bx.span_y = 31'(clip_span(box_hi_y - box_lo_y));
        boxes_due.push_back(bx);
        box_open = 0;
    endfunction

    function void check_box(cbb_pkg::t_out_item got);
        cbb_pkg::t_out_item want;
        if (boxes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected box transaction: %h", got);
            return;
        end
        want = boxes_due.pop_front();
        if (got.min_x !== want.min_x || got.max_x !== want.max_x ||
            got.min_y !== want.min_y || got.max_y !== want.max_y ||
            got.span_x !== want.span_x || got.span_y !== want.span_y) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"box mismatch: exp x[%0d,%0d] y[%0d,%0d] span %0d,%0d",
                          " / got x[%0d,%0d] y[%0d,%0d] span %0d,%0d"},
                         want.min_x, want.max_x, want.min_y, want.max_y,
                         want.span_x, want.span_y, got.min_x, got.max_x,
                         got.min_y, got.max_y, got.span_x, got.span_y);
        end
    endfunction
endclass

module compound_body_bounding_box_tb;
    import cbb_pkg::*;

    localparam int STALL_LIMIT = 4000;   // cycles without any transaction
    localparam int HOLD_OFF    = 600;    // long receiver stall, fills the queue
    localparam int RANDOM_ITEMS = 680;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_item o_item;

    box_scoreboard boxes = new();
    int  items_in = 0;
    int  quiet_cycles = 0;
    bit  hold_done = 0;

    compound_body_bounding_box dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always #4 i_clk = ~i_clk;

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Monitors: sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            boxes.note_input(i_item);
            items_in++;
        end
        if (i_rst_n && o_valid && i_ready)
            boxes.check_box(o_item);
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random ready, one long hold-off after 150 accepted inputs.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && items_in >= 150) begin
                hold_done = 1;
                i_ready = 0;
                repeat (HOLD_OFF) @(negedge i_clk);
            end
            gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            if (gap > 0) begin
                i_ready = 0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                i_ready = 1;
            end
        end
    end

    // Offer one transaction after a random gap; returns at the falling edge
    // right after acceptance with valid still high.
    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_item  = it;
        i_valid = 1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic t_in_item rand_prim(bit wide);
        t_in_item it;
        it.kind       = 1'($urandom_range(0, 1));
        it.prim_angle = 16'($urandom);
        it.body_angle = 16'($urandom);
        it.last       = 0;
        it.is_empty   = 0;
        if (wide) begin
            it.pos_x  = $urandom;
            it.pos_y  = $urandom;
            it.width  = 31'($urandom);
            it.height = 31'($urandom);
            it.radius = 31'($urandom);
        end else begin
            it.pos_x  = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            it.pos_y  = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            it.width  = 31'($urandom_range(0, 32'h003F_FFFF));
            it.height = 31'($urandom_range(0, 32'h003F_FFFF));
            it.radius = 31'($urandom_range(0, 32'h003F_FFFF));
        end
        return it;
    endfunction

    // Directed body: one primitive with chosen extremes, closed by last.
    task automatic send_single(bit kind, logic signed [31:0] ox, logic signed [31:0] oy,
                               logic signed [15:0] pa, logic signed [15:0] ba,
                               logic [30:0] sz);
        t_in_item it;
        it = '0;
        it.kind = kind; it.pos_x = ox; it.pos_y = oy;
        it.prim_angle = pa; it.body_angle = ba;
        it.width = sz; it.height = sz; it.radius = sz;
        it.last = 1;
        send_item(it);
    endtask

    initial begin
        t_in_item it;
        int       n_prims, body_angle_keep, sent;
        boxes.clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes of offsets, sizes and angles, both kinds.
        send_single(0, 0, 0, 0, 0, 0);
        send_single(1, 0, 0, 0, 0, 0);
        send_single(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sh7FFF, 16'sh7FFF, 31'h7FFF_FFFF);
        send_single(1, 32'sh8000_0000, 32'sh8000_0000, 16'sh8000, 16'sh8000, 31'h7FFF_FFFF);
        send_single(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh7FFF, 31'h7FFF_FFFF);
        send_single(0, 32'sh0001_0000, 32'sh0002_0000, 16'sd6434, 16'sd0, 31'h0004_0000);
        send_single(0, 32'sh0001_0000, 32'sh0002_0000, -16'sd6434, 16'sd12868, 31'h0004_0000);
        send_single(1, 32'sh0010_0000, -32'sh0010_0000, 16'sh7FFF, 16'sd6434, 31'h0001_0000);
        // Circle angle has no effect: same circle, different own angle.
        send_single(1, 32'sh0010_0000, -32'sh0010_0000, 16'sh8000, 16'sd6434, 31'h0001_0000);
        // Empty body on its own.
        it = '0; it.is_empty = 1; it.pos_x = 32'hFFFF_FFFF; it.last = 1;
        send_item(it);
        // Empty mark mid-body discards the primitives gathered so far.
        it = rand_prim(1); send_item(it);
        it = '0; it.is_empty = 1; send_item(it);
        // Unused sizes: circle with huge width/height, rectangle with huge radius.
        it = rand_prim(0); it.kind = 1; it.width = '1; it.height = '1; it.last = 1;
        send_item(it);
        it = rand_prim(0); it.kind = 0; it.radius = '1; it.last = 1;
        send_item(it);
        // Span overflow: two far-apart circles in one body.
        it = '0; it.kind = 1; it.pos_x = 32'sh7000_0000; it.pos_y = 32'sh7000_0000;
        it.radius = 31'h0100_0000; send_item(it);
        it.pos_x = -32'sh7000_0000; it.pos_y = -32'sh7000_0000; it.last = 1;
        send_item(it);

        // Random bodies of 1..6 primitives sharing a body angle; a few
        // broken bodies (empty mid-body) and lone empties.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            n_prims = $urandom_range(1, 6);
            body_angle_keep = $urandom;
            for (int k = 0; k < n_prims; k++) begin
                it = rand_prim($urandom_range(0, 4) == 0);
                it.body_angle = body_angle_keep[15:0];
                it.last = (k == n_prims - 1);
                if ($urandom_range(0, 29) == 0) begin
                    it.is_empty = 1;
                    it.last = 1'($urandom_range(0, 1));
                end
                send_item(it);
                sent++;
                if (it.is_empty) break;
            end
            if ($urandom_range(0, 14) == 0) begin
                it = rand_prim(1);
                it.is_empty = 1;
                send_item(it);
                sent++;
            end
        end
        i_valid = 0;

        // Drain: wait for every box, then let the back end settle.
        while (boxes.boxes_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (boxes.mismatches == 0 && boxes.boxes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/cbb_pkg.sv
rtl/core/cbb_front.sv
rtl/core/cbb_back.sv
rtl/core/compound_body_bounding_box.sv
tb/compound_body_bounding_box_tb.sv
